// ===== hdl/sgdn_pkg.sv =====
package sgdn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SIG_ENTRIES = 256;
    localparam int LOG_ENTRIES = 256;
    localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
    localparam int LOG_BITS    = $clog2(LOG_ENTRIES);
    localparam int LN2_Q16     = 45426;
    localparam int CFG_IDX_W   = 3;
    localparam int MUL_W       = 35;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int SAT_W       = 52;
    localparam int ACC_LO_W    = 20;
    localparam int ACC_W       = 39;
    localparam int LACC_W      = 56;

    localparam logic [15:0] LEAK_RESET = 16'd655;
    localparam logic [15:0] RATE_RESET = 16'd6554;
    localparam logic signed [31:0] INIT_W1_RESET = 32'sd65536;
    localparam logic signed [31:0] INIT_B1_RESET = 32'sd65536;
    localparam logic signed [31:0] INIT_W2_RESET = 32'sd131072;
    localparam logic signed [31:0] INIT_B2_RESET = 32'sd65536;

    localparam logic [CFG_IDX_W-1:0] REG_LEAK_SLOPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_W1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_B1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_W2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_B2    = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Z1,
        ST_Z2,
        ST_L1,
        ST_L2,
        ST_DIFF,
        ST_SIG,
        ST_PROB,
        ST_G1,
        ST_G2,
        ST_T1,
        ST_T2,
        ST_ACC,
        ST_LLO,
        ST_LHI,
        ST_LOSS,
        ST_ERR,
        ST_GRAD,
        ST_WUPD,
        ST_BUPD,
        ST_BCAP,
        ST_DONE
    } sgdn_state_t;

    typedef logic [16:0] sig_tab_t [0:SIG_ENTRIES];
    typedef logic [16:0] log_tab_t [0:LOG_ENTRIES];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, dvs}) begin
                rem = rem - {1'b0, dvs};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic sig_tab_t build_sig_tab();
        sig_tab_t    tab;
        logic [63:0] h;
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        h = (64'd8 << 30) / SIG_ENTRIES;
        t = 64'd1 << 30;
        r = 64'd1 << 30;
        e = 64'd1 << 30;
        for (int k = 1; k <= 20; k++) begin
            t = udiv64((t * h) >> 30, 64'(k));
            if (k[0] == 1'b1) begin
                r = r - t;
            end else begin
                r = r + t;
            end
        end
        for (int i = 0; i <= SIG_ENTRIES; i++) begin
            den = (64'd1 << 30) + e;
            tab[i] = 17'(udiv64((64'd1 << 46) + den / 2, den));
            e = (e * r) >> 30;
        end
        return tab;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] y;
        logic [63:0] acc;
        for (int i = 0; i <= LOG_ENTRIES; i++) begin
            y = (64'd1 << 30) + ((64'(i) << 30) / LOG_ENTRIES);
            acc = 64'd0;
            if (y >= (64'd2 << 30)) begin
                acc = 64'd1 << 20;
            end else begin
                for (int b = 20; b > 0; b--) begin
                    y = (y * y) >> 30;
                    if (y >= (64'd2 << 30)) begin
                        y = y >> 1;
                        acc = acc | (64'd1 << (b - 1));
                    end
                end
            end
            tab[i] = 17'((acc + 64'd8) >> 4);
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();
    localparam log_tab_t LOG_TAB = build_log_tab();

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFFFFFF);
        lo = -SAT_W'(32'sh7FFFFFFF) - SAT_W'(1);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hdl/sgdn_ifs.sv =====
interface sgdn_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_x;
    logic [16:0]        target_first;
    logic [16:0]        target_second;
    logic               reload_weights;

    modport source (output valid, sample_x, target_first, target_second, reload_weights,
                    input ready);
    modport sink (input valid, sample_x, target_first, target_second, reload_weights,
                  output ready);
endinterface

interface sgdn_result_if;
    logic               valid;
    logic               ready;
    logic [16:0]        prob_first;
    logic [16:0]        prob_second;
    logic [23:0]        loss_value;
    logic signed [31:0] new_slope_first;
    logic signed [31:0] new_bias_first;
    logic signed [31:0] new_slope_second;
    logic signed [31:0] new_bias_second;

    modport source (output valid, prob_first, prob_second, loss_value, new_slope_first,
                    new_bias_first, new_slope_second, new_bias_second, input ready);
    modport sink (input valid, prob_first, prob_second, loss_value, new_slope_first,
                  new_bias_first, new_slope_second, new_bias_second, output ready);
endinterface

interface sgdn_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/online_sgd_two_class_neuron_core.sv =====
// A sample transfer starts the sequencer, which ends by loading the result into the output register.
// A new sample is taken only in the idle state; a single 35x35 multiplier is shared by
// nineteen dependent products under the sequencer, and each product is registered in prod_reg.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_n, asynchronous, active low) loads the register and weight reset values.
module online_sgd_two_class_neuron_core (
    input  logic          clk,
    input  logic          rst_n,
    sgdn_sample_if.sink   sample,
    sgdn_result_if.source result,
    sgdn_cfg_if.sink      cfg
);
    import sgdn_pkg::*;

    localparam int SIG_SH = FRAC_BITS + 3;
    localparam int SIG_POS_W = 33 + SIG_BITS;
    localparam int LOG_POS_W = 16 + LOG_BITS;

    sgdn_state_t state_reg, state_next;

    logic [15:0]        leak_reg, rate_reg;
    logic signed [31:0] iw1_reg, ib1_reg, iw2_reg, ib2_reg;
    logic signed [31:0] w1_reg, b1_reg, w2_reg, b2_reg;
    logic signed [31:0] x_reg, z1_reg, z2_reg, a1_reg;
    logic [16:0]        t1_reg, t2_reg, p1_reg, p2_reg;
    logic signed [32:0] d_reg;
    logic [16:0]        sbase_reg, lbase_reg;
    logic               sclamp_reg;
    logic [4:0]         lshift_reg;
    logic [20:0]        nl1_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [LACC_W-1:0]  lacc_reg;
    logic [23:0]        loss_reg;
    logic signed [17:0] err_reg;
    logic               cls_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               out_valid_reg;
    logic [16:0]        o_p1_reg, o_p2_reg;
    logic [23:0]        o_loss_reg;
    logic signed [31:0] o_w1_reg, o_b1_reg, o_w2_reg, o_b2_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_f, prod_16, prod_db;
    logic signed [31:0]       a2_val, z_sel, w_sel, b_sel;
    logic signed [17:0]       e_raw, e_adj;
    logic [32:0]              ad;
    logic [SIG_POS_W-1:0]     spos;
    logic [SIG_BITS-1:0]      sidx;
    logic [SIG_SH-1:0]        sfr;
    logic                     sclamp;
    logic [16:0]              lp;
    logic [4:0]               lk;
    logic [16:0]              lpm;
    logic [LOG_POS_W-1:0]     lpos;
    logic [LOG_BITS-1:0]      lidx;
    logic [16:0]              s_val, ldiff;
    logic [20:0]              nl_val;
    logic signed [31:0]       w_new, b_new;
    logic [LACC_W-1:0]        lsum;
    logic                     in_take, out_load;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_take      = sample.valid && sample.ready;
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    assign prod_f  = prod_reg >>> FRAC_BITS;
    assign prod_16 = prod_reg >>> 16;
    assign prod_db = prod_reg >>> (32 - FRAC_BITS);

    assign a2_val = (z2_reg > 0) ? z2_reg : prod_16[31:0];
    assign z_sel  = cls_reg ? z2_reg : z1_reg;
    assign w_sel  = cls_reg ? w2_reg : w1_reg;
    assign b_sel  = cls_reg ? b2_reg : b1_reg;
    assign e_raw  = cls_reg ? ($signed({1'b0, p2_reg}) - $signed({1'b0, t2_reg}))
                            : ($signed({1'b0, p1_reg}) - $signed({1'b0, t1_reg}));
    assign e_adj  = (z_sel <= 0) ? prod_16[17:0] : e_raw;

    assign ad     = d_reg[32] ? 33'(-d_reg) : 33'(d_reg);
    assign spos   = {ad, {SIG_BITS{1'b0}}};
    assign sclamp = (spos >> SIG_SH) >= SIG_POS_W'(SIG_ENTRIES);
    assign sidx   = spos[SIG_SH +: SIG_BITS];
    assign sfr    = spos[SIG_SH-1:0];

    assign lp = (state_reg == ST_G1) ? p1_reg : p2_reg;
    always_comb
    begin
        lk = 5'd0;
        for (int j = 0; j <= 16; j++) begin
            if (lp[j]) begin
                lk = 5'(j);
            end
        end
    end
    assign lpm   = lp << (5'd16 - lk);
    assign lpos  = {lpm[15:0], {LOG_BITS{1'b0}}};
    assign lidx  = lpos[LOG_POS_W-1:16];
    assign ldiff = LOG_TAB[32'(lidx) + 1] - LOG_TAB[lidx];

    assign s_val  = sclamp_reg ? sbase_reg : 17'(sbase_reg + 17'(prod_reg >> SIG_SH));
    assign nl_val = {lshift_reg, 16'd0} - 21'(lbase_reg + 17'(prod_reg >> 16));
    assign w_new  = sat32(SAT_W'(w_sel) - prod_16[SAT_W-1:0]);
    assign b_new  = sat32(SAT_W'(b_sel) - prod_db[SAT_W-1:0]);
    assign lsum   = lacc_reg + (LACC_W'(prod_reg[LACC_W-1:0]) << ACC_LO_W);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_Z1;
            ST_Z1:   state_next = ST_Z2;
            ST_Z2:   state_next = ST_L1;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SIG;
            ST_SIG:  state_next = ST_PROB;
            ST_PROB: state_next = ST_G1;
            ST_G1:   state_next = ST_G2;
            ST_G2:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_LLO;
            ST_LLO:  state_next = ST_LHI;
            ST_LHI:  state_next = ST_LOSS;
            ST_LOSS: state_next = ST_ERR;
            ST_ERR:  state_next = ST_GRAD;
            ST_GRAD: state_next = ST_WUPD;
            ST_WUPD: state_next = ST_BUPD;
            ST_BUPD: state_next = ST_BCAP;
            ST_BCAP: state_next = cls_reg ? ST_DONE : ST_ERR;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_Z1:
            begin
                mul_a = MUL_W'(w1_reg);
                mul_b = MUL_W'(x_reg);
            end
            ST_Z2:
            begin
                mul_a = MUL_W'(w2_reg);
                mul_b = MUL_W'(x_reg);
            end
            ST_L1:
            begin
                mul_a = MUL_W'(z1_reg);
                mul_b = $signed(MUL_W'(leak_reg));
            end
            ST_L2:
            begin
                mul_a = MUL_W'(z2_reg);
                mul_b = $signed(MUL_W'(leak_reg));
            end
            ST_SIG:
            begin
                mul_a = $signed(MUL_W'(17'(SIG_TAB[32'(sidx) + 1] - SIG_TAB[sidx])));
                mul_b = $signed(MUL_W'(sfr));
            end
            ST_G1, ST_G2:
            begin
                mul_a = $signed(MUL_W'(ldiff));
                mul_b = $signed(MUL_W'(lpos[15:0]));
            end
            ST_T1:
            begin
                mul_a = $signed(MUL_W'(t2_reg));
                mul_b = $signed(MUL_W'(nl_val));
            end
            ST_T2:
            begin
                mul_a = $signed(MUL_W'(t1_reg));
                mul_b = $signed(MUL_W'(nl1_reg));
            end
            ST_LLO:
            begin
                mul_a = $signed(MUL_W'(acc_reg[ACC_LO_W-1:0]));
                mul_b = MUL_W'(LN2_Q16);
            end
            ST_LHI:
            begin
                mul_a = $signed(MUL_W'(acc_reg[ACC_W-1:ACC_LO_W]));
                mul_b = MUL_W'(LN2_Q16);
            end
            ST_ERR:
            begin
                mul_a = MUL_W'(e_raw);
                mul_b = $signed(MUL_W'(leak_reg));
            end
            ST_GRAD:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(e_adj);
            end
            ST_WUPD:
            begin
                mul_a = prod_16[MUL_W-1:0];
                mul_b = $signed(MUL_W'(rate_reg));
            end
            ST_BUPD:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed(MUL_W'(rate_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            leak_reg      <= LEAK_RESET;
            rate_reg      <= RATE_RESET;
            iw1_reg       <= INIT_W1_RESET;
            ib1_reg       <= INIT_B1_RESET;
            iw2_reg       <= INIT_W2_RESET;
            ib2_reg       <= INIT_B2_RESET;
            w1_reg        <= INIT_W1_RESET;
            b1_reg        <= INIT_B1_RESET;
            w2_reg        <= INIT_W2_RESET;
            b2_reg        <= INIT_B2_RESET;
            cls_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid) begin
                case (cfg.index)
                    REG_LEAK_SLOPE: leak_reg <= cfg.data[15:0];
                    REG_LEARN_RATE: rate_reg <= cfg.data[15:0];
                    REG_INIT_W1:    iw1_reg <= cfg.data;
                    REG_INIT_B1:    ib1_reg <= cfg.data;
                    REG_INIT_W2:    iw2_reg <= cfg.data;
                    REG_INIT_B2:    ib2_reg <= cfg.data;
                    default:        ;
                endcase
            end
            if (in_take && sample.reload_weights) begin
                w1_reg <= iw1_reg;
                b1_reg <= ib1_reg;
                w2_reg <= iw2_reg;
                b2_reg <= ib2_reg;
            end
            if (state_reg == ST_LOSS) begin
                cls_reg <= 1'b0;
            end
            if (state_reg == ST_BUPD) begin
                if (cls_reg) w2_reg <= w_new; else w1_reg <= w_new;
            end
            if (state_reg == ST_BCAP) begin
                if (cls_reg) b2_reg <= b_new; else b1_reg <= b_new;
                cls_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_take) begin
            x_reg  <= sample.sample_x;
            t1_reg <= sample.target_first;
            t2_reg <= sample.target_second;
        end
        case (state_reg)
            ST_Z2:   z1_reg <= sat32(prod_f[SAT_W-1:0] + SAT_W'(b1_reg));
            ST_L1:   z2_reg <= sat32(prod_f[SAT_W-1:0] + SAT_W'(b2_reg));
            ST_L2:   a1_reg <= (z1_reg > 0) ? z1_reg : prod_16[31:0];
            ST_DIFF: d_reg <= 33'(a1_reg) - 33'(a2_val);
            ST_SIG:
            begin
                sclamp_reg <= sclamp;
                sbase_reg  <= sclamp ? SIG_TAB[SIG_ENTRIES] : SIG_TAB[sidx];
            end
            ST_PROB:
            begin
                p1_reg <= d_reg[32] ? (17'd65536 - s_val) : s_val;
                p2_reg <= d_reg[32] ? s_val : (17'd65536 - s_val);
            end
            ST_G1:
            begin
                lshift_reg <= 5'd16 - lk;
                lbase_reg  <= LOG_TAB[lidx];
            end
            ST_G2:
            begin
                nl1_reg    <= nl_val;
                lshift_reg <= 5'd16 - lk;
                lbase_reg  <= LOG_TAB[lidx];
            end
            ST_T2:   acc_reg <= prod_reg[ACC_W-1:0];
            ST_ACC:  acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            ST_LHI:  lacc_reg <= LACC_W'(prod_reg[LACC_W-1:0]);
            ST_LOSS: loss_reg <= (lsum[LACC_W-1:32] > 24'hFFFFFF) ? 24'hFFFFFF
                                                                  : lsum[55:32];
            ST_GRAD: err_reg <= e_adj;
            default: ;
        endcase
        if (out_load) begin
            o_p1_reg   <= p1_reg;
            o_p2_reg   <= p2_reg;
            o_loss_reg <= loss_reg;
            o_w1_reg   <= w1_reg;
            o_b1_reg   <= b1_reg;
            o_w2_reg   <= w2_reg;
            o_b2_reg   <= b2_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.prob_first       = o_p1_reg;
    assign result.prob_second      = o_p2_reg;
    assign result.loss_value       = o_loss_reg;
    assign result.new_slope_first  = o_w1_reg;
    assign result.new_bias_first   = o_b1_reg;
    assign result.new_slope_second = o_w2_reg;
    assign result.new_bias_second  = o_b2_reg;

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == ST_Z1)
        else $error("sample transfer did not start the sequence");

    a_prob_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_G1 |-> (18'(p1_reg) + 18'(p2_reg)) == 18'd65536)
        else $error("probabilities do not sum to one");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared outside the final step");

    a_class_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOSS |=> !cls_reg)
        else $error("update did not start with the first class");
endmodule
